### hdl/svs_pkg.sv
// Shared types for the sorted value set: request and status codes,
// and the command word broadcast to the cell row. No dependencies.
package svs_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_ERASE  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic               ins_en;
    logic               del_en;
    logic signed [15:0] value;
  } svs_cmd_t;

endpackage

### hdl/svs_cell.sv
// One storage cell of the sorted value set: holds one entry, compares it
// against the broadcast value and shifts with its neighbors. Uses svs_pkg.
module svs_cell (
  input  logic                  clk,
  input  svs_pkg::svs_cmd_t     cmd,
  input  logic                  valid,
  input  logic                  after_pos,
  input  logic                  open_left,
  input  logic                  eq_left,
  input  logic signed [15:0]    entry_left,
  input  logic signed [15:0]    entry_right,
  output logic signed [15:0]    entry,
  output logic                  open_slot,
  output logic                  eq,
  output logic                  ins_first,
  output logic                  find_first
);
  import svs_pkg::*;

  assign open_slot  = !valid || (entry > cmd.value);
  assign eq         = valid && (entry == cmd.value);
  assign ins_first  = open_slot && !open_left;
  assign find_first = eq && !eq_left;

  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      if (open_left) begin
        entry <= entry_left;
      end else if (open_slot) begin
        entry <= cmd.value;
      end
    end else if (cmd.del_en && after_pos) begin
      entry <= entry_right;
    end
  end

endmodule

### hdl/sorted_value_set.sv
// Top level of the sorted value set: a row of svs_cell entries, the count
// register and the output register. Uses svs_pkg and svs_cell.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | tuser: req_type; tdata: value, position
//   m_      | out | m_tvalid/m_tready  | tdata: status, hit, result_index, entry_count
//
// Every request is handled by all cells at once: they compare and shift in parallel.
// The result is registered and appears the cycle after acceptance.
// s_tready is high while the output register is empty or being drained.
// Reset clears the count and the output valid; entry contents are not cleared.
module sorted_value_set #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] value, [19:16] position, [23:20] zero
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [1:0] status, [2] hit, [7:3] result_index,
                                 // [12:8] entry_count, [15:13] zero
);
  import svs_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               fire;
  req_t               req;
  logic signed [15:0] value;
  logic [3:0]         position;
  logic [CW+3:0]      pos_x;
  logic               full;
  logic               range_err;
  svs_cmd_t           cmd;

  logic signed [15:0] entry      [CAPACITY];
  logic [CAPACITY-1:0] open_slot;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] ins_first;
  logic [CAPACITY-1:0] find_first;

  logic [CW-1:0]      slot_idx;
  logic [CW-1:0]      find_idx;
  status_t            status;
  logic               hit;
  logic [CW-1:0]      idx;
  logic [CW+4:0]      idx_x;
  logic [CW+4:0]      cnt_x;

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;
  assign req      = req_t'(s_tuser);
  assign value    = s_tdata[15:0];
  assign position = s_tdata[19:16];
  assign pos_x    = (CW+4)'(position);

  assign full      = count >= CW'(CAPACITY);
  assign range_err = pos_x >= (CW+4)'(count);

  assign cmd.ins_en = fire && (req == REQ_INSERT) && !full;
  assign cmd.del_en = fire && (req == REQ_ERASE) && !range_err;
  assign cmd.value  = value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               open_left;
    logic               eq_left;
    logic signed [15:0] entry_left;
    logic signed [15:0] entry_right;

    if (i == 0) begin : g_first
      assign open_left  = 1'b0;
      assign eq_left    = 1'b0;
      assign entry_left = value;
    end else begin : g_mid
      assign open_left  = open_slot[i-1];
      assign eq_left    = eq[i-1];
      assign entry_left = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign entry_right = entry[i];
    end else begin : g_inner
      assign entry_right = entry[i+1];
    end

    svs_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .valid       (CW'(i) < count),
      .after_pos   ((CW+4)'(i) >= pos_x),
      .open_left   (open_left),
      .eq_left     (eq_left),
      .entry_left  (entry_left),
      .entry_right (entry_right),
      .entry       (entry[i]),
      .open_slot   (open_slot[i]),
      .eq          (eq[i]),
      .ins_first   (ins_first[i]),
      .find_first  (find_first[i])
    );
  end

  always_comb begin
    slot_idx = '0;
    find_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ins_first[i]) slot_idx = slot_idx | CW'(i);
      if (find_first[i]) find_idx = find_idx | CW'(i);
    end
  end

  always_comb begin
    status     = ST_OK;
    hit        = 1'b0;
    idx        = '0;
    count_next = count;
    unique case (req)
      REQ_INSERT: begin
        if (full) begin
          status = ST_FULL;
          idx    = count;
        end else begin
          idx        = slot_idx;
          count_next = count + CW'(1);
        end
      end
      REQ_FIND: begin
        hit = |eq;
        idx = hit ? find_idx : count;
      end
      REQ_ERASE: begin
        idx = CW'(pos_x);
        if (range_err) begin
          status = ST_RANGE;
        end else begin
          count_next = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign idx_x = (CW+5)'(position) & {(CW+5){req == REQ_ERASE}}
               | (CW+5)'(idx) & {(CW+5){req != REQ_ERASE}};
  assign cnt_x = (CW+5)'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {3'b000, cnt_x[4:0], idx_x[4:0], hit, status};
    end
  end

endmodule

### hdl/svs_checker.sv
// Port-level checks for sorted_value_set, bound to the top level.
// Depends only on the top level's ports.
module svs_checker #(
  parameter int CAPACITY = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted request produced no result word");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (CAPACITY < 32) |-> m_tdata[12:8] <= 5'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] && (CAPACITY < 32) |->
      m_tdata[1:0] == 2'd0 && m_tdata[7:3] < m_tdata[12:8])
    else $error("hit reported outside stored range");

endmodule

bind sorted_value_set svs_checker #(.CAPACITY(CAPACITY)) u_svs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
